[src/i2w_pkg.sv]
// Package for the integer-to-word-token block: word codes, queue entry type,
// and the decimal conversion and token classification functions.
// Depends on nothing; used by every other file of the block.
package i2w_pkg;

    localparam int VALUE_W        = 31;
    localparam int NUM_STAGES     = 8;
    localparam int BITS_PER_STAGE = 4;
    localparam int BIN_W          = NUM_STAGES * BITS_PER_STAGE;
    localparam int NUM_DIGITS     = 10;
    localparam int BCD_W          = NUM_DIGITS * 4;
    localparam int NUM_GROUPS     = 4;
    localparam int SLOTS_PER_GRP  = 5;
    localparam int NUM_SLOTS      = NUM_GROUPS * SLOTS_PER_GRP;
    localparam int WORD_W         = 5;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QUEUE_PTR_W    = $clog2(QUEUE_DEPTH);

    localparam logic [WORD_W-1:0] WORD_ZERO      = 5'd0;
    localparam logic [WORD_W-1:0] WORD_TEEN_BASE = 5'd10;
    localparam logic [WORD_W-1:0] WORD_TENS_BASE = 5'd18;
    localparam logic [WORD_W-1:0] WORD_HUNDRED   = 5'd28;
    localparam logic [WORD_W-1:0] WORD_THOUSAND  = 5'd29;
    localparam logic [WORD_W-1:0] WORD_MILLION   = 5'd30;
    localparam logic [WORD_W-1:0] WORD_BILLION   = 5'd31;

    // Slot positions inside one three-digit group.
    localparam int SLOT_HUND_DIGIT = 0;
    localparam int SLOT_HUNDRED    = 1;
    localparam int SLOT_TENS       = 2;
    localparam int SLOT_UNITS      = 3;
    localparam int SLOT_SCALE      = 4;

    typedef struct packed {
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } i2w_conv_t;

    // One queue entry: which token slots are present and the code of each.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]             mask;
        logic [NUM_SLOTS-1:0][WORD_W-1:0] codes;
    } i2w_entry_t;

    // One shift-add-3 step of the binary to decimal conversion.
    function automatic logic [BCD_W-1:0] dd_shift(logic [BCD_W-1:0] bcd, logic b);
        logic [BCD_W-1:0] adj;
        logic [3:0]       digit;
        adj = bcd;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit = bcd[4*i +: 4];
            if (digit >= 4'd5)
            begin
                digit = digit + 4'd3;
            end
            adj[4*i +: 4] = digit;
        end
        return {adj[BCD_W-2:0], b};
    endfunction

    // Consumes the top BITS_PER_STAGE bits of the remaining binary word.
    function automatic i2w_conv_t dd_stage(i2w_conv_t st);
        i2w_conv_t r;
        r = st;
        for (int k = 0; k < BITS_PER_STAGE; k++)
        begin
            r.bcd = dd_shift(r.bcd, r.bin[BIN_W-1]);
            r.bin = {r.bin[BIN_W-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] scale_word(int g);
        logic [WORD_W-1:0] w;
        case (g)
            0:       w = WORD_BILLION;
            1:       w = WORD_MILLION;
            default: w = WORD_THOUSAND;
        endcase
        return w;
    endfunction

    // Turns the ten decimal digits into the set of token slots to emit.
    function automatic i2w_entry_t classify(logic [BCD_W-1:0] bcd);
        i2w_entry_t e;
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] u;
        int         base;
        e = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            base = g * SLOTS_PER_GRP;
            if (g == 0)
            begin
                h = 4'd0;
                t = 4'd0;
                u = bcd[BCD_W-1 -: 4];
            end
            else
            begin
                u = bcd[4*(3*(3-g)) +: 4];
                t = bcd[4*(3*(3-g)+1) +: 4];
                h = bcd[4*(3*(3-g)+2) +: 4];
            end
            if (h != 4'd0)
            begin
                e.mask[base+SLOT_HUND_DIGIT]  = 1'b1;
                e.codes[base+SLOT_HUND_DIGIT] = {1'b0, h};
                e.mask[base+SLOT_HUNDRED]     = 1'b1;
                e.codes[base+SLOT_HUNDRED]    = WORD_HUNDRED;
            end
            if (t >= 4'd2)
            begin
                e.mask[base+SLOT_TENS]  = 1'b1;
                e.codes[base+SLOT_TENS] = WORD_TENS_BASE + {1'b0, t};
            end
            if (t == 4'd1)
            begin
                e.mask[base+SLOT_UNITS]  = 1'b1;
                e.codes[base+SLOT_UNITS] = WORD_TEEN_BASE + {1'b0, u};
            end
            else if (u != 4'd0)
            begin
                e.mask[base+SLOT_UNITS]  = 1'b1;
                e.codes[base+SLOT_UNITS] = {1'b0, u};
            end
            if ((g != NUM_GROUPS - 1) && ((h | t | u) != 4'd0))
            begin
                e.mask[base+SLOT_SCALE]  = 1'b1;
                e.codes[base+SLOT_SCALE] = scale_word(g);
            end
        end
        if (bcd == '0)
        begin
            e.mask[(NUM_GROUPS-1)*SLOTS_PER_GRP+SLOT_UNITS]  = 1'b1;
            e.codes[(NUM_GROUPS-1)*SLOTS_PER_GRP+SLOT_UNITS] = WORD_ZERO;
        end
        return e;
    endfunction

endpackage

[src/i2w_front.sv]
// Front part: eight-stage binary to BCD pipeline, one value per cycle unless
// a full queue stalls it; classifies digits into token slots. Depends on i2w_pkg.
module i2w_front
    import i2w_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [VALUE_W-1:0]   in_value,
    output logic                 out_valid,
    input  logic                 out_ready,
    output i2w_entry_t           out_entry
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    i2w_conv_t             stage_reg  [NUM_STAGES];
    i2w_conv_t             stage_next [NUM_STAGES];
    i2w_conv_t             stage_in;
    logic                  advance;

    // The whole pipeline moves unless a finished value waits on a full queue.
    assign advance   = !valid_reg[NUM_STAGES-1] || out_ready;
    assign in_ready  = advance;
    assign out_valid = valid_reg[NUM_STAGES-1];
    assign out_entry = classify(stage_reg[NUM_STAGES-1].bcd);

    always_comb
    begin
        for (int s = 0; s < NUM_STAGES; s++)
        begin
            if (s == 0)
            begin
                stage_in.bcd  = '0;
                stage_in.bin  = {{(BIN_W-VALUE_W){1'b0}}, in_value};
                valid_next[s] = in_valid;
            end
            else
            begin
                stage_in      = stage_reg[s-1];
                valid_next[s] = valid_reg[s-1];
            end
            stage_next[s] = dd_stage(stage_in);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int s = 0; s < NUM_STAGES; s++)
            begin
                stage_reg[s] <= stage_next[s];
            end
        end
    end

endmodule

[src/i2w_queue.sv]
// Two-entry queue of classified values between the front and the emitter.
// Depends on i2w_pkg.
module i2w_queue
    import i2w_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  i2w_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop,
    output i2w_entry_t pop_entry
);

    i2w_entry_t             entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != QUEUE_DEPTH[QUEUE_PTR_W:0]);
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[src/i2w_emit.sv]
// Back part: walks the present token slots of one value, lowest slot first,
// and drives a registered output beat per token. Depends on i2w_pkg.
module i2w_emit
    import i2w_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_pop,
    input  i2w_entry_t        q_entry,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [WORD_W-1:0] out_word,
    output logic              out_last
);

    logic [NUM_SLOTS-1:0]             mask_reg;
    logic [NUM_SLOTS-1:0]             mask_next;
    logic [NUM_SLOTS-1:0][WORD_W-1:0] codes_reg;
    logic [NUM_SLOTS-1:0][WORD_W-1:0] codes_next;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    logic [WORD_W-1:0]                out_word_reg;
    logic [WORD_W-1:0]                out_word_next;
    logic                             out_last_reg;
    logic                             out_last_next;
    logic [NUM_SLOTS-1:0]             low_bit;
    logic [NUM_SLOTS-1:0]             rest;
    logic [WORD_W-1:0]                sel_code;
    logic                             slot_free;
    logic                             emit;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign out_last  = out_last_reg;

    always_comb
    begin
        slot_free = !out_valid_reg || out_ready;
        low_bit   = mask_reg & (~mask_reg + 1'b1);
        rest      = mask_reg & ~low_bit;
        sel_code  = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            sel_code = sel_code | (codes_reg[i] & {WORD_W{low_bit[i]}});
        end
        emit  = slot_free && (mask_reg != '0);
        // Fetch the next value when idle or while sending the final token.
        q_pop = q_valid && ((mask_reg == '0) || (emit && (rest == '0)));

        mask_next      = mask_reg;
        codes_next     = codes_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            mask_next      = rest;
            out_valid_next = 1'b1;
            out_word_next  = sel_code;
            out_last_next  = (rest == '0);
        end
        else if (slot_free)
        begin
            out_valid_next = 1'b0;
        end
        if (q_pop)
        begin
            mask_next  = q_entry.mask;
            codes_next = q_entry.codes;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        codes_reg    <= codes_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

endmodule

[src/integer_to_word_tokens.sv]
// Top level of the integer-to-word-token block; uses i2w_pkg, i2w_front,
// i2w_queue and i2w_emit.
// One input beat per cycle enters the conversion pipeline unless a full queue
// stalls it, and one token per cycle leaves unless m_tready is low; a value
// yields 1 to 16 tokens, so the token output sets the rate.
// Reset (rst_n low, asynchronous) empties the pipeline, queue and output register.
module integer_to_word_tokens
    import i2w_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value, [31] ignored
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [4:0] word, [7:5] zero fill
    output logic        m_tlast    // last token of the value
);

    // The front converts each value to ten decimal digits over eight pipeline
    // stages (four bits per stage) and classifies the digits into twenty token
    // slots: per group a hundreds digit, Hundred, a tens word, a units or teen
    // word and a scale word. A two-entry queue decouples it from the emitter,
    // which sends the present slots in order and flags the final one.

    logic              fe_valid;
    logic              fe_ready;
    i2w_entry_t        fe_entry;
    logic              q_valid;
    logic              q_pop;
    i2w_entry_t        q_entry;
    logic [WORD_W-1:0] word;

    i2w_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  (s_tdata[VALUE_W-1:0]),
        .out_valid (fe_valid),
        .out_ready (fe_ready),
        .out_entry (fe_entry)
    );

    i2w_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_entry (fe_entry),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_entry  (q_entry)
    );

    i2w_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (word),
        .out_last  (m_tlast)
    );

    assign m_tdata = {{(8-WORD_W){1'b0}}, word};

`ifndef SYNTHESIS
    // The input side only stalls when a converted value waits on a full queue.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (fe_valid && !fe_ready))
        else $error("input stalled without a full queue");

    // The emitter never takes an entry from an empty queue.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // Zero is only ever spelled alone.
    a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (word == WORD_ZERO)) |-> m_tlast)
        else $error("Zero token not final");
`endif

endmodule
